[src/kvt_pkg.sv]
// Shared types and codes for the keyed value table.
package kvt_pkg;

    localparam int unsigned KEY_W = 64;
    localparam int unsigned VAL_W = 64;

    // Request types
    localparam logic REQ_GET         = 1'b0;
    localparam logic REQ_SET_DEFAULT = 1'b1;

    // Outcome codes
    localparam logic [1:0] OUTCOME_HIT     = 2'd0;
    localparam logic [1:0] OUTCOME_WRITTEN = 2'd1;
    localparam logic [1:0] OUTCOME_MISS    = 2'd2;
    localparam logic [1:0] OUTCOME_FULL    = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] default_value;
    } kv_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] result_value;
        logic [1:0]       outcome;
    } kv_resp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kv_entry_t;

endpackage

[src/kvt_mem.sv]
// Entry store: one write port and one read port with registered read data.
module kvt_mem
    import kvt_pkg::*;
#(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  kv_entry_t         wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output kv_entry_t         rd_data
);

    kv_entry_t mem [DEPTH];
    kv_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/kvt_ctrl.sv]
// Scan sequencer: walks the entry store, decides the outcome, writes back.
module kvt_ctrl
    import kvt_pkg::*;
#(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned IDX_W   = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  kv_req_t          req,
    output logic             res_valid,
    input  logic             res_ready,
    output kv_resp_t         res,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output kv_entry_t        wr_data,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    input  kv_entry_t        rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RESULT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t               state_reg,     state_next;
    kv_req_t              req_reg,       req_next;
    logic [IDX_W-1:0]     scan_idx_reg,  scan_idx_next;
    logic                 found_reg,     found_next;
    logic [IDX_W-1:0]     hit_idx_reg,   hit_idx_next;
    logic [VAL_W-1:0]     hit_value_reg, hit_value_next;
    logic                 free_ok_reg,   free_ok_next;
    logic [IDX_W-1:0]     free_idx_reg,  free_idx_next;
    logic [ENTRIES-1:0]   used_reg,      used_next;
    kv_resp_t             resp_reg,      resp_next;

    logic scan_used;
    logic key_match;

    assign scan_used = used_reg[scan_idx_reg];
    assign key_match = (rd_data.key == req_reg.lookup_key);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_value_next = hit_value_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        used_next      = used_reg;
        resp_next      = resp_reg;

        req_ready = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = scan_idx_reg + IDX_W'(1);
        wr_en     = 1'b0;
        wr_addr   = hit_idx_reg;
        wr_data   = '{key: req_reg.lookup_key, value: req_reg.default_value};

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next      = req;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    free_ok_next  = 1'b0;
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Read data belongs to scan_idx_reg this cycle
                if (scan_used && key_match)
                begin
                    found_next     = 1'b1;
                    hit_idx_next   = scan_idx_reg;
                    hit_value_next = rd_data.value;
                    state_next     = S_DECIDE;
                end
                else
                begin
                    if (!scan_used && !free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = scan_idx_reg;
                    end
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
            end

            S_DECIDE:
            begin
                priority if (req_reg.req_type == REQ_GET)
                begin
                    if (found_reg)
                    begin
                        resp_next = '{result_value: hit_value_reg, outcome: OUTCOME_HIT};
                    end
                    else
                    begin
                        resp_next = '{result_value: '0, outcome: OUTCOME_MISS};
                    end
                end
                else if (found_reg)
                begin
                    if (hit_value_reg != '0)
                    begin
                        resp_next = '{result_value: hit_value_reg, outcome: OUTCOME_HIT};
                    end
                    else
                    begin
                        // Zero value: take the default in place
                        wr_en     = 1'b1;
                        wr_addr   = hit_idx_reg;
                        resp_next = '{result_value: req_reg.default_value,
                                      outcome: OUTCOME_WRITTEN};
                    end
                end
                else if (free_ok_reg)
                begin
                    wr_en               = 1'b1;
                    wr_addr             = free_idx_reg;
                    used_next[free_idx_reg] = 1'b1;
                    resp_next = '{result_value: req_reg.default_value,
                                  outcome: OUTCOME_WRITTEN};
                end
                else
                begin
                    resp_next = '{result_value: '0, outcome: OUTCOME_FULL};
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = resp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            hit_value_reg <= '0;
            free_ok_reg   <= 1'b0;
            free_idx_reg  <= '0;
            used_reg      <= '0;
            resp_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            scan_idx_reg  <= scan_idx_next;
            found_reg     <= found_next;
            hit_idx_reg   <= hit_idx_next;
            hit_value_reg <= hit_value_next;
            free_ok_reg   <= free_ok_next;
            free_idx_reg  <= free_idx_next;
            used_reg      <= used_next;
            resp_reg      <= resp_next;
        end
    end

endmodule

[src/keyed_value_table_set_default.sv]
// Top level of the keyed value table with get and set-default requests.
//
//   channel | beat type | handshake              | role
//   --------+-----------+------------------------+-------------------------------
//   req     | kv_req_t  | req_valid / req_ready  | get or set-default request in
//   resp    | kv_resp_t | resp_valid / resp_ready| value plus outcome code out
//
// One request at a time. A request reads one entry per cycle from the entry
// store (one read port, registered read data); the scan stops at the first
// matching key or after the last entry, then the outcome is decided and the
// result goes to the response register.
// Reset clears the used marks at once; keys and values need no clearing.
// A stalled response sits in the output register; the next request is taken
// while it waits, and its own result holds in the sequencer until it frees.
module keyed_value_table_set_default
    import kvt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  kv_req_t  req,
    output logic     resp_valid,
    input  logic     resp_ready,
    output kv_resp_t resp
);

    // Entry index width; at least one bit for a single-entry table
    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    kv_entry_t        wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    kv_entry_t        rd_data;

    logic     res_valid;
    logic     res_ready;
    kv_resp_t res;

    logic     resp_valid_reg, resp_valid_next;
    kv_resp_t resp_reg,       resp_next;

    kvt_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kvt_ctrl #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Output register: load when empty or draining this cycle
    assign res_ready = !resp_valid_reg || resp_ready;

    always_comb
    begin
        resp_valid_next = resp_valid_reg;
        resp_next       = resp_reg;
        if (res_valid && res_ready)
        begin
            resp_valid_next = 1'b1;
            resp_next       = res;
        end
        else if (resp_ready)
        begin
            // Drop the beat once taken
            resp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
            resp_reg       <= '0;
        end
        else
        begin
            resp_valid_reg <= resp_valid_next;
            resp_reg       <= resp_next;
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

endmodule

[src/kvt_checker.sv]
// Port-level checks for the keyed value table, bound to the top level.
module kvt_checker
    import kvt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input kv_req_t  req,
    input logic     resp_valid,
    input logic     resp_ready,
    input kv_resp_t resp
);

    // Hold a stalled response beat
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(resp))
        else $error("response beat changed while stalled");

    // A miss returns zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp.outcome == OUTCOME_MISS |-> resp.result_value == '0)
        else $error("miss with nonzero value");

    // A full table returns zero
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && resp.outcome == OUTCOME_FULL |-> resp.result_value == '0)
        else $error("full table with nonzero value");

    // One request in flight: no accept on the cycle after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

endmodule

bind keyed_value_table_set_default kvt_checker u_kvt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
);
